// ----- hdl/flat_shaded_triangle_normal_emitter_top_assert.svh -----
// Assertion macros for the triangle normal emitter checker.
// Depends on nothing; the including module provides clock and reset.
`ifndef FLAT_SHADED_TRIANGLE_NORMAL_EMITTER_TOP_ASSERT_SVH
`define FLAT_SHADED_TRIANGLE_NORMAL_EMITTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSNE_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fsne check failed");

// Consequent must hold in the cycle after the antecedent.
`define FSNE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fsne check failed");

`endif

// ----- hdl/fsne_pkg.sv -----
// Shared types and constants for the triangle normal emitter.
// No dependencies.
package fsne_pkg;

   localparam int COORD_WIDTH      = 20;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int NORM_WIDTH       = NORMAL_FRAC_BITS + 2;
   localparam int INDEX_WIDTH      = 32;
   localparam int MAG_LIMIT        = 30;

   localparam int EDGE_SHIFT  = (COORD_WIDTH > MAG_LIMIT) ? COORD_WIDTH - MAG_LIMIT : 0;
   localparam int EDGE_WIDTH  = (COORD_WIDTH > MAG_LIMIT) ? MAG_LIMIT + 1 : COORD_WIDTH + 1;
   localparam int CROSS_WIDTH = 2 * EDGE_WIDTH + 1;
   localparam int MAG_WIDTH   = (2 * EDGE_WIDTH > MAG_LIMIT + 1) ? 2 * EDGE_WIDTH
                                                                 : MAG_LIMIT + 1;
   localparam int SUMSQ_WIDTH = 2 * MAG_LIMIT + 2;
   localparam int LEN_WIDTH   = MAG_LIMIT + 1;
   localparam int DIVIDEND_WIDTH = MAG_LIMIT + NORMAL_FRAC_BITS + 1;
   localparam int STEP_WIDTH  = $clog2(NORM_WIDTH + 6);
   localparam int CROSS_LAST  = 5;
   localparam int SQUARE_LAST = 2;

   typedef struct packed {
      logic                            first_triangle;
      logic signed [COORD_WIDTH-1:0]   v0_x;
      logic signed [COORD_WIDTH-1:0]   v0_y;
      logic signed [COORD_WIDTH-1:0]   v0_z;
      logic signed [COORD_WIDTH-1:0]   v1_x;
      logic signed [COORD_WIDTH-1:0]   v1_y;
      logic signed [COORD_WIDTH-1:0]   v1_z;
      logic signed [COORD_WIDTH-1:0]   v2_x;
      logic signed [COORD_WIDTH-1:0]   v2_y;
      logic signed [COORD_WIDTH-1:0]   v2_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0]   pos_x;
      logic signed [COORD_WIDTH-1:0]   pos_y;
      logic signed [COORD_WIDTH-1:0]   pos_z;
      logic signed [NORM_WIDTH-1:0]    norm_x;
      logic signed [NORM_WIDTH-1:0]    norm_y;
      logic signed [NORM_WIDTH-1:0]    norm_z;
      logic [INDEX_WIDTH-1:0]          vertex_index;
      logic                            last_of_triangle;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CROSS,
      ST_ABS,
      ST_SCALE,
      ST_SQUARE,
      ST_SQRT,
      ST_PREP,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

// ----- hdl/flat_shaded_triangle_normal_emitter_top.sv -----
// Flat-shaded triangle normal emitter, top level.
// Depends on fsne_pkg.
//
// Takes one triangle (three Q8.12 vertex positions) per request transaction and
// returns three response transactions, one per unwelded vertex, each with its
// position, the shared unit face normal in Q2.14 and a running vertex index;
// the third is flagged last. A triangle occupies the block for a cross
// product through one shared multiplier, one-bit right shifts to bring the cross
// product below 2^30, squaring, a bit-serial square root (one result bit per
// cycle), three parallel bit-serial quotient lanes, plus capture, setup and the
// three output transactions, plus any response stall. req_ready is high only
// while idle; a zero cross product gives a zero normal. Setting first_triangle
// restarts the vertex index at zero; otherwise it runs on modulo 2^32.
module flat_shaded_triangle_normal_emitter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fsne_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fsne_pkg::rsp_type rsp_data
);
   import fsne_pkg::*;

   state_type state_ff, state_in;

   // Control registers
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic [1:0]              vtx_ff, vtx_in;
   logic [INDEX_WIDTH-1:0]  cnt_ff, cnt_in;

   // Datapath registers
   logic signed [COORD_WIDTH-1:0] pos_ff [3][3];
   logic signed [EDGE_WIDTH-1:0]  e_ff [3], e_in [3];
   logic signed [EDGE_WIDTH-1:0]  f_ff [3], f_in [3];
   logic signed [CROSS_WIDTH-1:0] n_ff [3], n_in [3];
   logic [MAG_WIDTH-1:0]          m_ff [3], m_in [3];
   logic [2:0]                    sgn_ff, sgn_in;
   logic [SUMSQ_WIDTH-1:0]        x_ff, x_in;
   logic [SUMSQ_WIDTH-1:0]        res_ff, res_in;
   logic [SUMSQ_WIDTH-1:0]        bit_ff, bit_in;
   logic [LEN_WIDTH-1:0]          len_ff, len_in;
   logic [LEN_WIDTH-1:0]          rem_ff [3], rem_in [3];
   logic [NORM_WIDTH-1:0]         dq_ff [3], dq_in [3];

   // Combinational helpers
   logic signed [COORD_WIDTH-1:0] vin [3][3];
   logic                          req_fire, rsp_fire;
   logic signed [EDGE_WIDTH-1:0]  mul_a, mul_b;
   logic signed [2*EDGE_WIDTH-1:0] prod;
   logic [1:0]                    cross_idx;
   logic                          cross_sub;
   logic [MAG_LIMIT-1:0]          sq_op;
   logic [2*MAG_LIMIT-1:0]        sq;
   logic [SUMSQ_WIDTH-1:0]        root_try;
   logic                          mag_big;
   logic [DIVIDEND_WIDTH-1:0]     dvd [3];
   logic [LEN_WIDTH:0]            div_try [3];
   logic                          div_ge [3];
   logic [NORM_WIDTH-1:0]         q_sat [3];
   logic signed [NORM_WIDTH-1:0]  norm [3];

   localparam logic [NORM_WIDTH-1:0] NormOne = NORM_WIDTH'(1) << NORMAL_FRAC_BITS;

   // Edge difference with the magnitude shift that wide coordinates need.
   function automatic logic signed [EDGE_WIDTH-1:0] edge_of(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b
   );
      logic signed [COORD_WIDTH:0] d;
      logic [COORD_WIDTH:0]        mag;
      logic [COORD_WIDTH:0]        sh;
      d   = (COORD_WIDTH+1)'(a) - (COORD_WIDTH+1)'(b);
      mag = d[COORD_WIDTH] ? (COORD_WIDTH+1)'(-d) : (COORD_WIDTH+1)'(d);
      sh  = mag >> EDGE_SHIFT;
      return d[COORD_WIDTH] ? EDGE_WIDTH'(-sh) : EDGE_WIDTH'(sh);
   endfunction

   assign vin[0][0] = req_data.v0_x;
   assign vin[0][1] = req_data.v0_y;
   assign vin[0][2] = req_data.v0_z;
   assign vin[1][0] = req_data.v1_x;
   assign vin[1][1] = req_data.v1_y;
   assign vin[1][2] = req_data.v1_z;
   assign vin[2][0] = req_data.v2_x;
   assign vin[2][1] = req_data.v2_y;
   assign vin[2][2] = req_data.v2_z;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Handshake outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_CROSS;
         ST_CROSS:  if (step_ff == STEP_WIDTH'(CROSS_LAST)) state_in = ST_ABS;
         ST_ABS:    state_in = ST_SCALE;
         ST_SCALE:  if (!mag_big) state_in = ST_SQUARE;
         ST_SQUARE: if (step_ff == STEP_WIDTH'(SQUARE_LAST)) state_in = ST_SQRT;
         ST_SQRT:   if (bit_ff[0]) state_in = ST_PREP;
         ST_PREP:   state_in = ST_DIV;
         ST_DIV:    if (step_ff == STEP_WIDTH'(NORM_WIDTH - 1)) state_in = ST_EMIT;
         ST_EMIT:   if (rsp_fire && vtx_ff == 2'd2) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Cross product operand selection: one signed multiply per cycle
   always_comb begin
      case (step_ff)
         STEP_WIDTH'(0): begin mul_a = e_ff[1]; mul_b = f_ff[2]; end
         STEP_WIDTH'(1): begin mul_a = e_ff[2]; mul_b = f_ff[1]; end
         STEP_WIDTH'(2): begin mul_a = e_ff[2]; mul_b = f_ff[0]; end
         STEP_WIDTH'(3): begin mul_a = e_ff[0]; mul_b = f_ff[2]; end
         STEP_WIDTH'(4): begin mul_a = e_ff[0]; mul_b = f_ff[1]; end
         STEP_WIDTH'(5): begin mul_a = e_ff[1]; mul_b = f_ff[0]; end
         default:        begin mul_a = '0;      mul_b = '0;      end
      endcase
   end

   assign prod      = mul_a * mul_b;
   assign cross_idx = step_ff[2:1];
   assign cross_sub = step_ff[0];

   assign sq_op    = m_ff[step_ff[1:0]][MAG_LIMIT-1:0];
   assign sq       = sq_op * sq_op;
   assign root_try = res_ff + bit_ff;
   assign mag_big  = (|m_ff[0][MAG_WIDTH-1:MAG_LIMIT]) || (|m_ff[1][MAG_WIDTH-1:MAG_LIMIT])
                  || (|m_ff[2][MAG_WIDTH-1:MAG_LIMIT]);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dvd[i] = DIVIDEND_WIDTH'({m_ff[i][MAG_LIMIT-1:0], {NORMAL_FRAC_BITS{1'b0}}})
                + DIVIDEND_WIDTH'(res_ff[LEN_WIDTH-1:0] >> 1);
         div_try[i] = {rem_ff[i], dq_ff[i][NORM_WIDTH-1]};
         div_ge[i]  = (div_try[i] >= {1'b0, len_ff});
         q_sat[i]   = (dq_ff[i] > NormOne) ? NormOne : dq_ff[i];
         if (len_ff == '0) norm[i] = '0;
         else if (sgn_ff[i]) norm[i] = NORM_WIDTH'(-q_sat[i]);
         else norm[i] = q_sat[i];
      end
   end

   // Datapath next values
   always_comb begin
      step_in = step_ff;
      vtx_in  = vtx_ff;
      cnt_in  = cnt_ff;
      e_in    = e_ff;
      f_in    = f_ff;
      n_in    = n_ff;
      m_in    = m_ff;
      sgn_in  = sgn_ff;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      len_in  = len_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      case (state_ff)
         ST_IDLE: begin
            // Capture edges, clear accumulators
            for (int i = 0; i < 3; i++) begin
               e_in[i] = edge_of(vin[1][i], vin[0][i]);
               f_in[i] = edge_of(vin[2][i], vin[0][i]);
               n_in[i] = '0;
            end
            step_in = '0;
            vtx_in  = '0;
            if (req_fire && req_data.first_triangle) cnt_in = '0;
         end
         ST_CROSS: begin
            n_in[cross_idx] = cross_sub ? n_ff[cross_idx] - CROSS_WIDTH'(prod)
                                        : n_ff[cross_idx] + CROSS_WIDTH'(prod);
            step_in = step_ff + STEP_WIDTH'(1);
         end
         ST_ABS: begin
            for (int i = 0; i < 3; i++) begin
               sgn_in[i] = n_ff[i][CROSS_WIDTH-1];
               m_in[i]   = n_ff[i][CROSS_WIDTH-1] ? MAG_WIDTH'(-n_ff[i])
                                                  : MAG_WIDTH'(n_ff[i]);
            end
         end
         ST_SCALE: begin
            // Shift all magnitudes together until the largest is below 2^30
            if (mag_big) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 1;
            end else begin
               step_in = '0;
               x_in    = '0;
               res_in  = '0;
               bit_in  = SUMSQ_WIDTH'(1) << (SUMSQ_WIDTH - 2);
            end
         end
         ST_SQUARE: begin
            x_in    = x_ff + SUMSQ_WIDTH'(sq);
            step_in = step_ff + STEP_WIDTH'(1);
         end
         ST_SQRT: begin
            // One root bit per cycle
            if (x_ff >= root_try) begin
               x_in   = x_ff - root_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         ST_PREP: begin
            len_in  = res_ff[LEN_WIDTH-1:0];
            step_in = '0;
            for (int i = 0; i < 3; i++) begin
               rem_in[i] = LEN_WIDTH'(dvd[i] >> NORM_WIDTH);
               dq_in[i]  = dvd[i][NORM_WIDTH-1:0];
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per lane per cycle
            for (int i = 0; i < 3; i++) begin
               rem_in[i] = div_ge[i] ? LEN_WIDTH'(div_try[i] - {1'b0, len_ff})
                                     : LEN_WIDTH'(div_try[i]);
               dq_in[i]  = {dq_ff[i][NORM_WIDTH-2:0], div_ge[i]};
            end
            step_in = step_ff + STEP_WIDTH'(1);
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               cnt_in = cnt_ff + INDEX_WIDTH'(1);
               vtx_in = vtx_ff + 2'd1;
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         vtx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         vtx_ff   <= vtx_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload and arithmetic state
   always_ff @(posedge clock) begin
      if (req_fire) pos_ff <= vin;
      e_ff   <= e_in;
      f_ff   <= f_in;
      n_ff   <= n_in;
      m_ff   <= m_in;
      sgn_ff <= sgn_in;
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      len_ff <= len_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   // Response payload: hold steady while the vertex waits
   always_comb begin
      rsp_data.pos_x            = pos_ff[vtx_ff][0];
      rsp_data.pos_y            = pos_ff[vtx_ff][1];
      rsp_data.pos_z            = pos_ff[vtx_ff][2];
      rsp_data.norm_x           = norm[0];
      rsp_data.norm_y           = norm[1];
      rsp_data.norm_z           = norm[2];
      rsp_data.vertex_index     = cnt_ff;
      rsp_data.last_of_triangle = (vtx_ff == 2'd2);
   end

endmodule

// ----- hdl/fsne_checker.sv -----
// Port-level checker for the triangle normal emitter, bound to the top level.
// Depends on fsne_pkg and flat_shaded_triangle_normal_emitter_top_assert.svh.
`include "flat_shaded_triangle_normal_emitter_top_assert.svh"

module fsne_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input fsne_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input fsne_pkg::rsp_type rsp_data
);
   import fsne_pkg::*;

   logic                   rsp_mid;
   logic [INDEX_WIDTH-1:0] index_next;

   // A vertex other than the last one of its triangle is taken
   assign rsp_mid    = rsp_valid && rsp_ready && !rsp_data.last_of_triangle;
   assign index_next = rsp_data.vertex_index + INDEX_WIDTH'(1);

   `FSNE_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
   `FSNE_ASSERT_SAME(a_no_overlap, req_ready, !rsp_valid)
   `FSNE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `FSNE_ASSERT_NEXT(a_index_step, rsp_mid, rsp_valid && (rsp_data.vertex_index == $past(index_next)))

endmodule

bind flat_shaded_triangle_normal_emitter_top fsne_checker u_fsne_checker (.*);
